// ===== hw/rtl/rvx_pkg.sv =====
// shared constants, codes and interface types of the rv32im subset executor
`timescale 1ns / 1ps
package rvx_pkg;

  localparam int DMEM_WORDS = 4096;
  localparam int DMEM_AW    = $clog2(DMEM_WORDS);
  localparam int RF_DEPTH   = 32;
  localparam int DIV_STEPS  = 32;
  localparam int DIV_CW     = $clog2(DIV_STEPS);

  localparam logic [31:0] RESET_PC    = 32'h8000_0000;
  localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;
  localparam logic [31:0] ALL_ONES    = 32'hffff_ffff;
  localparam logic [4:0]  A0_IDX      = 5'd10;
  localparam logic [4:0]  X0_IDX      = 5'd0;

  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  typedef enum logic [2:0] {
    ST_EXEC    = 3'd0,
    ST_GOOD    = 3'd1,
    ST_BAD     = 3'd2,
    ST_INVALID = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SEL_ALU,
    SEL_LOAD,
    SEL_MUL_LO,
    SEL_MUL_HI,
    SEL_DIV
  } res_sel_t;

  typedef struct packed {
    logic accept;
    logic dec;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_div;
    logic div_busy;
  } dp_stat_t;

endpackage

// ===== hw/rtl/rv32im_subset_executor.sv =====
// top level of the rv32im subset executor
// Takes one instruction word at a time, executes it at the current pc and
// returns one trace word. Most instructions pass from acceptance to result
// through register file read, decode and execute, and commit; div, divu, rem
// and remu also wait in a divide state on the 32-step restoring divider. The
// next word is accepted once the previous one has committed, even while its
// result still waits on the output register. A cfg_we write loads the pc
// at once.
`timescale 1ns / 1ps
module rv32im_subset_executor import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_inst_pc,
  output logic [31:0] out_next_pc,
  output logic        out_reg_write,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic [2:0]  out_status,
  output logic [31:0] out_halt_code,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  rvx_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  rvx_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
    .in_instruction(in_instruction), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_inst_pc(out_inst_pc), .out_next_pc(out_next_pc),
    .out_reg_write(out_reg_write), .out_reg_index(out_reg_index),
    .out_reg_value(out_reg_value), .out_status(out_status),
    .out_halt_code(out_halt_code)
  );

endmodule

// ===== hw/rtl/rvx_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
module rvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/rvx_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rvx_div import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        is_signed,
  input  logic        want_rem,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] result
);

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [31:0]       q_r;
  logic [31:0]       rem_r;
  logic [31:0]       d_r;
  logic              neg_q_r;
  logic              neg_r_r;
  logic              want_rem_r;
  logic              na;
  logic              nb;
  logic [33:0]       diff;
  logic              ge;

  assign na   = is_signed & dividend[31];
  assign nb   = is_signed & divisor[31];
  assign diff = {1'b0, rem_r, q_r[31]} - {2'b00, d_r};
  assign ge   = ~diff[33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r        <= na ? (32'd0 - dividend) : dividend;
      d_r        <= nb ? (32'd0 - divisor) : divisor;
      rem_r      <= '0;
      neg_q_r    <= (na ^ nb) & (divisor != 32'd0);
      neg_r_r    <= na;
      want_rem_r <= want_rem;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : {rem_r[30:0], q_r[31]};
      q_r   <= {q_r[30:0], ge};
    end
  end

  assign busy   = busy_r;
  assign result = want_rem_r ? (neg_r_r ? (32'd0 - rem_r) : rem_r)
                             : (neg_q_r ? (32'd0 - q_r) : q_r);

endmodule

// ===== hw/rtl/rvx_ctrl.sv =====
// sequencing state machine and output word handshake
`timescale 1ns / 1ps
module rvx_ctrl import rvx_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEC,
    S_DIV,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.accept = (state_r == S_IDLE) & in_valid;
    cmd.dec    = (state_r == S_DEC);
    cmd.commit = (state_r == S_FIN) & (~out_valid_r | out_ready);
    state_nxt  = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = stat.is_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (!stat.div_busy) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/rvx_dp.sv =====
// datapath: pc, register file, decode, alu, multiplier, divider, data memory
`timescale 1ns / 1ps
module rvx_dp import rvx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  logic [31:0] in_instruction,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic [31:0] out_inst_pc,
  output logic [31:0] out_next_pc,
  output logic        out_reg_write,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic [2:0]  out_status,
  output logic [31:0] out_halt_code
);

  logic [31:0] instr_r;
  logic [31:0] pc_r;
  logic        halted_r;
  logic        z1_r;
  logic        z2_r;

  logic        wr_r;
  logic [31:0] val_r;
  logic [31:0] next_r;
  status_t     status_r;
  logic [31:0] hc_r;
  res_sel_t    sel_r;
  logic [1:0]  ld_off_r;
  logic [65:0] prod_r;

  logic [31:0] out_inst_pc_r;
  logic [31:0] out_next_pc_r;
  logic        out_reg_write_r;
  logic [4:0]  out_reg_index_r;
  logic [31:0] out_reg_value_r;
  status_t     out_status_r;
  logic [31:0] out_halt_code_r;

  logic [4:0]  raddr1;
  logic [4:0]  raddr2;
  logic [31:0] rf1_q;
  logic [31:0] rf2_q;
  logic [31:0] s1;
  logic [31:0] s2;
  logic        rf_we;
  logic [31:0] val_fin;

  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_u;
  logic [31:0] imm_j;
  logic [4:0]  shamt;
  logic [31:0] ea;
  logic        lts;
  logic        ltu;

  logic        d_bad;
  logic        d_wr;
  logic [31:0] d_val;
  logic [31:0] d_next;
  status_t     d_status;
  logic [31:0] d_hc;
  res_sel_t    d_sel;
  logic        d_ld;
  logic        d_st;
  logic        d_div;
  logic        take;

  logic [1:0]         lane_k [4];
  logic [31:0]        lane_a [4];
  logic               lane_we [4];
  logic [7:0]         lane_wd [4];
  logic [7:0]         lane_q [4];
  logic [31:0]        div_res;
  logic               div_busy;
  logic [7:0]         b0;
  logic [7:0]         b1;
  logic [7:0]         b2;
  logic [7:0]         b3;

  assign raddr1 = (in_instruction == EBREAK_WORD) ? A0_IDX : in_instruction[19:15];
  assign raddr2 = in_instruction[24:20];
  assign rd     = instr_r[11:7];
  assign rf_we  = cmd.commit & wr_r & (rd != X0_IDX);

  rvx_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf1 (
    .clk(clk), .we(rf_we), .waddr(rd), .wdata(val_fin),
    .re(cmd.accept), .raddr(raddr1), .rdata(rf1_q)
  );

  rvx_ram #(.WIDTH(32), .DEPTH(RF_DEPTH)) u_rf2 (
    .clk(clk), .we(rf_we), .waddr(rd), .wdata(val_fin),
    .re(cmd.accept), .raddr(raddr2), .rdata(rf2_q)
  );

  assign s1 = z1_r ? 32'd0 : rf1_q;
  assign s2 = z2_r ? 32'd0 : rf2_q;

  assign op    = instr_r[6:0];
  assign f3    = instr_r[14:12];
  assign f7    = instr_r[31:25];
  assign imm_i = {{20{instr_r[31]}}, instr_r[31:20]};
  assign imm_s = {{20{instr_r[31]}}, instr_r[31:25], instr_r[11:7]};
  assign imm_b = {{19{instr_r[31]}}, instr_r[31], instr_r[7], instr_r[30:25],
                  instr_r[11:8], 1'b0};
  assign imm_u = {instr_r[31:12], 12'd0};
  assign imm_j = {{11{instr_r[31]}}, instr_r[31], instr_r[19:12], instr_r[20],
                  instr_r[30:21], 1'b0};
  assign shamt = (op == OP_IMM) ? instr_r[24:20] : s2[4:0];
  assign ea    = s1 + ((op == OP_STORE) ? imm_s : imm_i);
  assign lts   = $signed(s1) < $signed(s2);
  assign ltu   = s1 < s2;

  always_comb begin
    d_bad    = 1'b0;
    d_wr     = 1'b0;
    d_val    = 32'd0;
    d_next   = pc_r + 32'd4;
    d_status = ST_EXEC;
    d_hc     = 32'd0;
    d_sel    = SEL_ALU;
    d_ld     = 1'b0;
    d_st     = 1'b0;
    d_div    = 1'b0;
    take     = 1'b0;
    case (op)
      OP_BRANCH: begin
        case (f3)
          3'd0: take = (s1 == s2);
          3'd1: take = (s1 != s2);
          3'd4: take = lts;
          3'd5: take = ~lts;
          3'd6: take = ltu;
          3'd7: take = ~ltu;
          default: d_bad = 1'b1;
        endcase
        if (take) d_next = pc_r + imm_b;
      end
      OP_LOAD: begin
        d_wr  = 1'b1;
        d_sel = SEL_LOAD;
        d_ld  = 1'b1;
        case (f3)
          3'd1, 3'd2, 3'd4, 3'd5: d_bad = 1'b0;
          default: d_bad = 1'b1;
        endcase
      end
      OP_STORE: begin
        if (f3 <= 3'd2) d_st = 1'b1;
        else d_bad = 1'b1;
      end
      OP_IMM: begin
        d_wr = 1'b1;
        case (f3)
          3'd0: d_val = s1 + imm_i;
          3'd3: d_val = {31'd0, s1 < imm_i};
          3'd4: d_val = s1 ^ imm_i;
          3'd7: d_val = s1 & imm_i;
          3'd1: begin
            if (f7 == F7_BASE) d_val = s1 << shamt;
            else d_bad = 1'b1;
          end
          3'd5: begin
            if (f7 == F7_BASE) d_val = s1 >> shamt;
            else if (f7 == F7_ALT) d_val = 32'($signed(s1) >>> shamt);
            else d_bad = 1'b1;
          end
          default: d_bad = 1'b1;
        endcase
      end
      OP_REG: begin
        d_wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: d_val = s1 + s2;
            3'd1: d_val = s1 << shamt;
            3'd2: d_val = {31'd0, lts};
            3'd3: d_val = {31'd0, ltu};
            3'd4: d_val = s1 ^ s2;
            3'd5: d_val = s1 >> shamt;
            3'd6: d_val = s1 | s2;
            default: d_val = s1 & s2;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          d_val = s1 - s2;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          d_val = 32'($signed(s1) >>> shamt);
        end else if (f7 == F7_MULDIV) begin
          case (f3)
            3'd0: d_sel = SEL_MUL_LO;
            3'd1: d_sel = SEL_MUL_HI;
            3'd4, 3'd5, 3'd6, 3'd7: begin
              d_sel = SEL_DIV;
              d_div = 1'b1;
            end
            default: d_bad = 1'b1;
          endcase
        end else begin
          d_bad = 1'b1;
        end
      end
      OP_LUI: begin
        d_wr  = 1'b1;
        d_val = imm_u;
      end
      OP_AUIPC: begin
        d_wr  = 1'b1;
        d_val = pc_r + imm_u;
      end
      OP_JAL: begin
        d_wr   = 1'b1;
        d_val  = pc_r + 32'd4;
        d_next = pc_r + imm_j;
      end
      OP_JALR: begin
        if (f3 == 3'd0) begin
          d_wr   = 1'b1;
          d_val  = pc_r + 32'd4;
          d_next = (s1 + imm_i) & 32'hffff_fffe;
        end else begin
          d_bad = 1'b1;
        end
      end
      OP_SYSTEM: begin
        if (instr_r == EBREAK_WORD) begin
          d_hc     = s1;
          d_status = (s1 == 32'd0) ? ST_GOOD : ST_BAD;
        end else begin
          d_bad = 1'b1;
        end
      end
      default: d_bad = 1'b1;
    endcase
    if (d_bad) begin
      d_wr     = 1'b0;
      d_val    = 32'd0;
      d_next   = pc_r + 32'd4;
      d_status = ST_INVALID;
      d_hc     = ALL_ONES;
      d_sel    = SEL_ALU;
      d_ld     = 1'b0;
      d_st     = 1'b0;
      d_div    = 1'b0;
    end
    if (halted_r) begin
      d_wr     = 1'b0;
      d_val    = 32'd0;
      d_next   = pc_r;
      d_status = ST_IGNORED;
      d_hc     = 32'd0;
      d_sel    = SEL_ALU;
      d_ld     = 1'b0;
      d_st     = 1'b0;
      d_div    = 1'b0;
    end
  end

  // one byte lane per ram, each lane touched at most once per access
  for (genvar l = 0; l < 4; l++) begin : g_lane
    assign lane_k[l]  = 2'(l) - ea[1:0];
    assign lane_a[l]  = ea + {30'd0, lane_k[l]};
    assign lane_we[l] = cmd.dec & d_st &
                        ((lane_k[l] == 2'd0) ||
                         (f3[1:0] == 2'd1 && lane_k[l] == 2'd1) ||
                         (f3[1:0] == 2'd2));
    assign lane_wd[l] = 8'(s2 >> {lane_k[l], 3'b000});

    rvx_ram #(.WIDTH(8), .DEPTH(DMEM_WORDS)) u_dmem (
      .clk(clk), .we(lane_we[l]), .waddr(lane_a[l][DMEM_AW+1:2]), .wdata(lane_wd[l]),
      .re(cmd.dec & d_ld), .raddr(lane_a[l][DMEM_AW+1:2]), .rdata(lane_q[l])
    );
  end

  rvx_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.dec & d_div),
    .is_signed(~f3[0]), .want_rem(f3[1]),
    .dividend(s1), .divisor(s2), .busy(div_busy), .result(div_res)
  );

  assign stat.is_div   = d_div;
  assign stat.div_busy = div_busy;

  assign b0 = lane_q[ld_off_r];
  assign b1 = lane_q[2'(ld_off_r + 2'd1)];
  assign b2 = lane_q[2'(ld_off_r + 2'd2)];
  assign b3 = lane_q[2'(ld_off_r + 2'd3)];

  always_comb begin
    case (sel_r)
      SEL_ALU:    val_fin = val_r;
      SEL_MUL_LO: val_fin = prod_r[31:0];
      SEL_MUL_HI: val_fin = prod_r[63:32];
      SEL_DIV:    val_fin = div_res;
      SEL_LOAD: begin
        case (f3)
          3'd1:    val_fin = {{16{b1[7]}}, b1, b0};
          3'd2:    val_fin = {b3, b2, b1, b0};
          3'd4:    val_fin = {24'd0, b0};
          default: val_fin = {16'd0, b1, b0};
        endcase
      end
      default: val_fin = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= RESET_PC;
      halted_r <= 1'b0;
    end else if (cfg_we) begin
      pc_r <= cfg_wdata;
    end else if (cmd.commit) begin
      pc_r <= next_r;
      if (status_r == ST_GOOD || status_r == ST_BAD || status_r == ST_INVALID) begin
        halted_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      instr_r <= in_instruction;
      z1_r    <= (raddr1 == X0_IDX);
      z2_r    <= (raddr2 == X0_IDX);
    end
    if (cmd.dec) begin
      wr_r     <= d_wr;
      val_r    <= d_val;
      next_r   <= d_next;
      status_r <= d_status;
      hc_r     <= d_hc;
      sel_r    <= d_sel;
      ld_off_r <= ea[1:0];
      prod_r   <= 66'($signed({s1[31], s1}) * $signed({s2[31], s2}));
    end
    if (cmd.commit) begin
      out_inst_pc_r   <= pc_r;
      out_next_pc_r   <= next_r;
      out_reg_write_r <= wr_r;
      out_reg_index_r <= wr_r ? rd : X0_IDX;
      out_reg_value_r <= wr_r ? val_fin : 32'd0;
      out_status_r    <= status_r;
      out_halt_code_r <= hc_r;
    end
  end

  assign out_inst_pc   = out_inst_pc_r;
  assign out_next_pc   = out_next_pc_r;
  assign out_reg_write = out_reg_write_r;
  assign out_reg_index = out_reg_index_r;
  assign out_reg_value = out_reg_value_r;
  assign out_status    = out_status_r;
  assign out_halt_code = out_halt_code_r;

endmodule

// ===== hw/rtl/rvx_chk.sv =====
// port level checker of the rv32im subset executor and its bind
`timescale 1ns / 1ps
module rvx_chk import rvx_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_instruction,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_inst_pc,
  input logic [31:0] out_next_pc,
  input logic        out_reg_write,
  input logic [4:0]  out_reg_index,
  input logic [31:0] out_reg_value,
  input logic [2:0]  out_status,
  input logic [31:0] out_halt_code,
  input logic        cfg_we,
  input logic [31:0] cfg_wdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inst_pc) && $stable(out_status))
    else $error("output word changed while stalled");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_write |-> out_reg_index == 5'd0 && out_reg_value == 32'd0)
    else $error("register fields set without a write");

  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_IGNORED |->
      !out_reg_write && out_next_pc == out_inst_pc && out_halt_code == 32'd0)
    else $error("ignored word has side effects");

  a_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_INVALID |->
      out_halt_code == ALL_ONES && out_next_pc == out_inst_pc + 32'd4 && !out_reg_write)
    else $error("invalid word fields wrong");

endmodule

bind rv32im_subset_executor rvx_chk u_rvx_chk (.*);

// ===== tb/sv/testbench.sv =====
// testbench for the rv32im subset executor: random programs checked against a predictor
`timescale 1ns / 1ps
module testbench;
  import rvx_pkg::*;

  typedef struct {
    logic [31:0] inst_pc;
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    status_t     status;
    logic [31:0] halt_code;
  } trace_t;

  localparam int MEM_BYTES = DMEM_WORDS * 4;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_instruction = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_inst_pc;
  logic [31:0] out_next_pc;
  logic        out_reg_write;
  logic [4:0]  out_reg_index;
  logic [31:0] out_reg_value;
  logic [2:0]  out_status;
  logic [31:0] out_halt_code;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  logic [31:0] word_queue[$];
  trace_t      trace_queue[$];
  logic [31:0] store_addrs[$];

  logic [31:0] model_regs[32];
  bit          reg_known[32];
  logic [7:0]  model_mem[MEM_BYTES];
  bit          byte_known[MEM_BYTES];
  logic [31:0] model_pc;
  bit          model_halted;

  int fails = 0;
  bit quiet = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  rv32im_subset_executor i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_instruction(in_instruction),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_inst_pc(out_inst_pc), .out_next_pc(out_next_pc),
    .out_reg_write(out_reg_write), .out_reg_index(out_reg_index),
    .out_reg_value(out_reg_value), .out_status(out_status),
    .out_halt_code(out_halt_code),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] load_bytes(logic [31:0] a, int n);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < n; k++) v[8*k +: 8] = model_mem[(a + k) % MEM_BYTES];
    return v;
  endfunction

  function automatic bit bytes_known(logic [31:0] a, int n);
    bit ok;
    ok = 1'b1;
    for (int k = 0; k < n; k++) ok &= byte_known[(a + k) % MEM_BYTES];
    return ok;
  endfunction

  // executes one instruction word against the modeled machine state
  function automatic trace_t execute_word(logic [31:0] w);
    trace_t      t;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] s1, s2, imm_i, imm_s, imm_b, imm_u, imm_j, nxt, val, a;
    logic        wr, bad, take;
    longint      prod;
    op = w[6:0]; f3 = w[14:12]; f7 = w[31:25]; rd = w[11:7];
    s1 = model_regs[w[19:15]];
    s2 = model_regs[w[24:20]];
    imm_i = {{20{w[31]}}, w[31:20]};
    imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    imm_u = {w[31:12], 12'b0};
    imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    t.inst_pc = model_pc;
    if (model_halted) begin
      t.next_pc = model_pc; t.reg_write = 1'b0; t.reg_index = '0;
      t.reg_value = '0; t.status = ST_IGNORED; t.halt_code = '0;
      return t;
    end
    nxt = model_pc + 32'd4; val = '0; wr = 1'b0; bad = 1'b0; take = 1'b0;
    t.status = ST_EXEC; t.halt_code = '0;
    case (op)
      OP_BRANCH: begin
        case (f3)
          3'd0: take = s1 == s2;
          3'd1: take = s1 != s2;
          3'd4: take = $signed(s1) < $signed(s2);
          3'd5: take = $signed(s1) >= $signed(s2);
          3'd6: take = s1 < s2;
          3'd7: take = s1 >= s2;
          default: bad = 1'b1;
        endcase
        if (take) nxt = model_pc + imm_b;
      end
      OP_LOAD: begin
        wr = 1'b1;
        a = s1 + imm_i;
        case (f3)
          3'd1: begin
            val = load_bytes(a, 2);
            val = {{16{val[15]}}, val[15:0]};
          end
          3'd2: val = load_bytes(a, 4);
          3'd4: val = load_bytes(a, 1);
          3'd5: val = load_bytes(a, 2);
          default: bad = 1'b1;
        endcase
      end
      OP_STORE: begin
        a = s1 + imm_s;
        if (f3 <= 3'd2) begin
          for (int k = 0; k < (1 << f3); k++) begin
            model_mem[(a + k) % MEM_BYTES] = s2[8*k +: 8];
            byte_known[(a + k) % MEM_BYTES] = 1'b1;
          end
        end else bad = 1'b1;
      end
      OP_IMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: val = s1 + imm_i;
          3'd3: val = {31'b0, s1 < imm_i};
          3'd4: val = s1 ^ imm_i;
          3'd7: val = s1 & imm_i;
          3'd1: if (f7 == F7_BASE) val = s1 << imm_i[4:0]; else bad = 1'b1;
          3'd5: begin
            if (f7 == F7_BASE) val = s1 >> imm_i[4:0];
            else if (f7 == F7_ALT) val = $signed(s1) >>> imm_i[4:0];
            else bad = 1'b1;
          end
          default: bad = 1'b1;
        endcase
      end
      OP_REG: begin
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: val = s1 + s2;
            3'd1: val = s1 << s2[4:0];
            3'd2: val = {31'b0, $signed(s1) < $signed(s2)};
            3'd3: val = {31'b0, s1 < s2};
            3'd4: val = s1 ^ s2;
            3'd5: val = s1 >> s2[4:0];
            3'd6: val = s1 | s2;
            default: val = s1 & s2;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) begin
          val = s1 - s2;
        end else if (f7 == F7_ALT && f3 == 3'd5) begin
          val = $signed(s1) >>> s2[4:0];
        end else if (f7 == F7_MULDIV) begin
          case (f3)
            3'd0: val = s1 * s2;
            3'd1: begin
              prod = longint'($signed(s1)) * longint'($signed(s2));
              val = prod[63:32];
            end
            3'd4: begin
              if (s2 == '0) val = ALL_ONES;
              else if (s1 == 32'h8000_0000 && s2 == ALL_ONES) val = s1;
              else val = $signed(s1) / $signed(s2);
            end
            3'd5: val = (s2 == '0) ? ALL_ONES : s1 / s2;
            3'd6: begin
              if (s2 == '0) val = s1;
              else if (s1 == 32'h8000_0000 && s2 == ALL_ONES) val = '0;
              else val = $signed(s1) % $signed(s2);
            end
            3'd7: val = (s2 == '0) ? s1 : s1 % s2;
            default: bad = 1'b1;
          endcase
        end else bad = 1'b1;
      end
      OP_LUI: begin wr = 1'b1; val = imm_u; end
      OP_AUIPC: begin wr = 1'b1; val = model_pc + imm_u; end
      OP_JAL: begin wr = 1'b1; val = model_pc + 32'd4; nxt = model_pc + imm_j; end
      OP_JALR: begin
        if (f3 == 3'd0) begin
          wr = 1'b1; val = model_pc + 32'd4; nxt = (s1 + imm_i) & 32'hffff_fffe;
        end else bad = 1'b1;
      end
      OP_SYSTEM: begin
        if (w == EBREAK_WORD) begin
          t.halt_code = model_regs[A0_IDX];
          t.status = (t.halt_code == '0) ? ST_GOOD : ST_BAD;
          model_halted = 1'b1;
        end else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      wr = 1'b0; val = '0; nxt = model_pc + 32'd4;
      t.status = ST_INVALID; t.halt_code = ALL_ONES; model_halted = 1'b1;
    end
    if (wr && rd != X0_IDX) begin
      model_regs[rd] = val;
      reg_known[rd] = 1'b1;
    end
    model_pc = nxt;
    t.next_pc = nxt;
    t.reg_write = wr;
    t.reg_index = wr ? rd : 5'd0;
    t.reg_value = wr ? val : 32'd0;
    return t;
  endfunction

  task automatic issue(logic [31:0] w);
    word_queue.push_back(w);
    trace_queue.push_back(execute_word(w));
  endtask

  function automatic logic [4:0] pick_src();
    logic [4:0] r;
    do r = 5'($urandom_range(0, 31)); while (!reg_known[r]);
    return r;
  endfunction

  // legal, non-halting random instruction; x2 stays the memory base
  function automatic logic [31:0] random_word();
    int          kind, n;
    logic [31:0] r, a, d;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [11:0] imm;
    while (1) begin
      kind = $urandom_range(0, 99);
      r = $urandom;
      rd = 5'($urandom_range(0, 31));
      if (rd == 5'd2) rd = X0_IDX;
      rs1 = pick_src();
      rs2 = pick_src();
      if (kind < 12) begin
        case ($urandom_range(0, 5))
          0: f3 = 3'd0; 1: f3 = 3'd3; 2: f3 = 3'd4; 3: f3 = 3'd7; 4: f3 = 3'd1;
          default: f3 = 3'd5;
        endcase
        imm = r[31:20];
        if (f3 == 3'd1) imm[11:5] = F7_BASE;
        if (f3 == 3'd5) imm[11:5] = r[0] ? F7_ALT : F7_BASE;
        return {imm, rs1, f3, rd, OP_IMM};
      end else if (kind < 30) begin
        f3 = r[2:0];
        return {(f3 == 3'd0 || f3 == 3'd5) && r[3] ? F7_ALT : F7_BASE,
                rs2, rs1, f3, rd, OP_REG};
      end else if (kind < 42) begin
        case ($urandom_range(0, 5))
          0: f3 = 3'd0; 1: f3 = 3'd1; 2: f3 = 3'd4; 3: f3 = 3'd5; 4: f3 = 3'd6;
          default: f3 = 3'd7;
        endcase
        return {F7_MULDIV, rs2, rs1, f3, rd, OP_REG};
      end else if (kind < 47) begin
        return {r[31:12], rd, OP_LUI};
      end else if (kind < 52) begin
        return {r[31:12], rd, OP_AUIPC};
      end else if (kind < 57) begin
        return {r[31:12], rd, OP_JAL};
      end else if (kind < 62) begin
        return {r[31:20], rs1, 3'd0, rd, OP_JALR};
      end else if (kind < 74) begin
        case ($urandom_range(0, 5))
          0: f3 = 3'd0; 1: f3 = 3'd1; 2: f3 = 3'd4; 3: f3 = 3'd5; 4: f3 = 3'd6;
          default: f3 = 3'd7;
        endcase
        return {r[31:25], rs2, rs1, f3, r[11:7], OP_BRANCH};
      end else if (kind < 86) begin
        if ($urandom_range(0, 9) < 7) rs1 = 5'd2;
        f3 = 3'($urandom_range(0, 2));
        store_addrs.push_back(model_regs[rs1] + {{20{r[31]}}, r[31:25], r[11:7]});
        return {r[31:25], rs2, rs1, f3, r[11:7], OP_STORE};
      end else if (store_addrs.size() > 0) begin
        if ($urandom_range(0, 9) < 7) rs1 = 5'd2;
        case ($urandom_range(0, 3))
          0: f3 = 3'd1; 1: f3 = 3'd2; 2: f3 = 3'd4; default: f3 = 3'd5;
        endcase
        n = (f3 == 3'd2) ? 4 : (f3 == 3'd4) ? 1 : 2;
        a = store_addrs[$urandom_range(0, store_addrs.size() - 1)] + $urandom_range(0, 3);
        d = (a - model_regs[rs1]) % MEM_BYTES;
        if (d < 2048) imm = d[11:0];
        else if (d >= MEM_BYTES - 2048) imm = d[11:0];
        else continue;
        if (!bytes_known(model_regs[rs1] + {{20{imm[11]}}, imm}, n)) continue;
        return {imm, rs1, f3, rd, OP_LOAD};
      end
    end
  endfunction

  function automatic logic [31:0] invalid_word();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return {r[31:15], r[0] ? 3'd2 : 3'd6, r[11:7], OP_IMM};
      1: return {r[31:15], r[12] ? 3'd0 : {r[14], 2'b11}, r[11:7], OP_LOAD};
      2: return {F7_MULDIV, r[24:15], 2'b01, r[12], r[11:7], OP_REG};
      3: return {r[31:15], 2'b01, r[12], r[11:7], OP_BRANCH};
      4: return {r[31:15], r[14:12] == 3'd0 ? 3'd3 : r[14:12] | 3'd3, r[11:7], OP_STORE};
      5: return {r[31:15], r[14:12] == 3'd0 ? 3'd1 : r[14:12], r[11:7], OP_JALR};
      6: return {r[31:7] == EBREAK_WORD[31:7] ? 25'd0 : r[31:7], OP_SYSTEM};
      default: return {7'h7f, r[24:15], 3'd1, r[11:7], OP_IMM};
    endcase
  endfunction

  // input side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(0, 12);
        in_valid <= 1'b0;
      end else if (word_queue.size() > 0) begin
        in_valid <= 1'b1;
        in_instruction <= word_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output side stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      out_gap <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    trace_t t;
    if (rst_n && out_valid && out_ready) begin
      if (trace_queue.size() == 0) begin
        $display("%0t unexpected word expected none actual pc %h", $time, out_inst_pc);
        fails++;
      end else begin
        t = trace_queue.pop_front();
        check_field("inst_pc", t.inst_pc, out_inst_pc);
        check_field("next_pc", t.next_pc, out_next_pc);
        check_field("reg_write", t.reg_write, out_reg_write);
        check_field("reg_index", t.reg_index, out_reg_index);
        check_field("reg_value", t.reg_value, out_reg_value);
        check_field("status", t.status, out_status);
        check_field("halt_code", t.halt_code, out_halt_code);
      end
    end
  end

  task automatic drain();
    while (trace_queue.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reset_vector(logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_pc = v;
  endtask

  initial begin
    logic [31:0] vectors[5];
    int          mode;
    vectors = '{32'h0000_0000, 32'hffff_ffff, $urandom, 32'h7fff_fffc, RESET_PC};
    for (int k = 0; k < 32; k++) begin
      model_regs[k] = '0;
      reg_known[k] = (k == 0);
    end
    for (int k = 0; k < MEM_BYTES; k++) begin
      model_mem[k] = '0;
      byte_known[k] = 1'b0;
    end
    model_pc = RESET_PC;
    model_halted = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 5; ph++) begin
      write_reset_vector(vectors[ph]);
      if (ph == 4) quiet = 1'b1;
      if (ph == 0) begin
        issue({12'hfff, X0_IDX, 3'd0, 5'd1, OP_IMM});
        issue({20'h80000, 5'd3, OP_LUI});
        issue({12'h7ff, X0_IDX, 3'd0, 5'd5, OP_IMM});
        issue({12'h800, X0_IDX, 3'd0, 5'd6, OP_IMM});
        issue({20'h00010, 5'd2, OP_LUI});
        issue({F7_BASE, 5'd1, 5'd1, 3'd0, X0_IDX, OP_REG});
        issue({F7_MULDIV, 5'd1, 5'd3, 3'd4, 5'd7, OP_REG});
        issue({F7_MULDIV, 5'd1, 5'd3, 3'd6, 5'd8, OP_REG});
        issue({F7_MULDIV, 5'd0, 5'd5, 3'd4, 5'd9, OP_REG});
        issue({F7_MULDIV, 5'd0, 5'd5, 3'd5, 5'd11, OP_REG});
        issue({F7_MULDIV, 5'd0, 5'd6, 3'd6, 5'd12, OP_REG});
        issue({F7_MULDIV, 5'd0, 5'd1, 3'd7, 5'd13, OP_REG});
        issue({F7_MULDIV, 5'd1, 5'd3, 3'd1, 5'd14, OP_REG});
        issue({7'h7f, 5'd1, 5'd2, 3'd2, 5'h1e, OP_STORE});
        issue({7'h00, 5'd3, 5'd2, 3'd2, 5'd2, OP_STORE});
        issue({7'h00, 5'd5, 5'd2, 3'd2, 5'd4, OP_STORE});
        issue({7'h00, 5'd6, 5'd2, 3'd0, 5'd7, OP_STORE});
        issue({12'hffe, 5'd2, 3'd2, 5'd15, OP_LOAD});
        issue({12'h003, 5'd2, 3'd2, 5'd16, OP_LOAD});
        issue({12'h006, 5'd2, 3'd1, 5'd17, OP_LOAD});
        issue({12'h006, 5'd2, 3'd5, 5'd18, OP_LOAD});
        issue({12'h007, 5'd2, 3'd4, 5'd19, OP_LOAD});
        issue({F7_ALT, 5'd31, 5'd3, 3'd5, 5'd20, OP_IMM});
        issue({F7_ALT, 5'd5, 5'd3, 3'd5, 5'd21, OP_REG});
        issue({12'hfff, 5'd1, 3'd0, 5'd22, OP_JALR});
        issue({7'h55, 5'd1, 5'd1, 3'd0, 5'h0b, OP_BRANCH});
        issue({7'h2a, 5'd3, 5'd5, 3'd6, 5'h15, OP_BRANCH});
      end
      for (int k = 0; k < 90; k++) issue(random_word());
      if (ph == 4) begin
        mode = $urandom_range(0, 2);
        if (mode == 2) begin
          issue(invalid_word());
        end else begin
          issue({mode == 0 ? 12'd0 : 12'($urandom_range(1, 4095)), X0_IDX, 3'd0, A0_IDX,
                 OP_IMM});
          issue(EBREAK_WORD);
        end
        repeat (5) issue($urandom);
      end
      drain();
    end

    if (fails == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rvx_pkg.sv
hw/rtl/rvx_ram.sv
hw/rtl/rvx_div.sv
hw/rtl/rvx_ctrl.sv
hw/rtl/rvx_dp.sv
hw/rtl/rv32im_subset_executor.sv
hw/rtl/rvx_chk.sv
tb/sv/testbench.sv
